// ===== src/bfsa_pkg.sv =====
// Package for the best-fit segment allocator.
// Holds table sizes, status codes and the packed segment entry type; no dependencies.
package bfsa_pkg;
   localparam int MaxSegs = 16;
   localparam int IdxW = $clog2(MaxSegs);
   localparam int CntW = $clog2(MaxSegs + 1);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOFIT = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_DUP = 3'd4;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic [15:0] RESET_TOTAL = 16'd10;

   typedef struct packed {
      logic [15:0] size;
      logic        used;
      logic [15:0] owner;
   } seg_type;
endpackage

// ===== src/bfsa_seg_ram.sv =====
// Segment table memory: one write port and one read port, registered read data.
// Uses bfsa_pkg for the entry type and depth.
module bfsa_seg_ram (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [bfsa_pkg::IdxW-1:0] wr_addr,
   input  bfsa_pkg::seg_type       wr_data,
   input  logic [bfsa_pkg::IdxW-1:0] rd_addr,
   output bfsa_pkg::seg_type       rd_data
);
   import bfsa_pkg::*;

   seg_type mem [MaxSegs];

   // Synchronous write and read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/best_fit_segment_allocator_top.sv =====
// Top level of the best-fit segment allocator.
// Uses bfsa_pkg and the segment memory bfsa_seg_ram.
//
// Channel  Direction  Handshake        Payload
// req      in         start & !busy    req_kind, req_process_id, req_request_size
// rsp      out        rsp_valid        rsp_status, rsp_seg_size, rsp_seg_used,
//                                      rsp_seg_owner, rsp_last
// csr      in         csr_we           csr_total_size
//
// An operation scans the table at one memory read a cycle, decides, then shifts
// entries (a read, then a write for each), then lists the table one word a cycle.
// A reset or a csr write holds the block busy while the table is cleared.
// Words are shown for one cycle; the receiver cannot stall.
module best_fit_segment_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [15:0] req_process_id,
   input  logic [15:0] req_request_size,
   input  logic        csr_we,
   input  logic [15:0] csr_total_size,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_seg_size,
   output logic        rsp_seg_used,
   output logic [15:0] rsp_seg_owner,
   output logic        rsp_last
);
   import bfsa_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_INS = 4'd4;
   localparam logic [3:0] S_MERGE = 4'd5;
   localparam logic [3:0] S_CLOSE = 4'd6;
   localparam logic [3:0] S_LIST = 4'd7;
   localparam logic [3:0] S_ERR = 4'd8;
   localparam logic [3:0] S_ZERO = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [15:0]     total_ff, total_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] ptr_ff, ptr_in;     // read address sent
   logic [CntW-1:0] pos_ff, pos_in;     // address whose data is in rd_data
   logic            rdv_ff, rdv_in;     // rd_data valid for pos_ff
   logic            kind_ff, kind_in;
   logic [15:0]     pid_ff, pid_in, req_ff, req_in;
   logic            own_ff, own_in, fit_ff, fit_in;
   logic [IdxW-1:0] best_ff, best_in;
   logic [15:0]     left_ff, left_in;
   logic            prev_free_ff, prev_free_in;
   logic [IdxW-1:0] lo_ff, lo_in;
   logic [CntW-1:0] hi_ff, hi_in;
   logic            hi_open_ff, hi_open_in;
   logic [15:0]     sum_ff, sum_in;
   logic [2:0]      err_ff, err_in;
   seg_type         hold_ff, hold_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   seg_type         wr_data, rd_data;

   bfsa_seg_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         total_ff <= RESET_TOTAL;
         count_ff <= '0;
         ptr_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         rdv_ff   <= rdv_in;
      end
      pos_ff <= pos_in;  kind_ff <= kind_in;  pid_ff <= pid_in;  req_ff <= req_in;
      own_ff <= own_in;  fit_ff <= fit_in;
      best_ff <= best_in;  left_ff <= left_in;  prev_free_ff <= prev_free_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  hi_open_ff <= hi_open_in;  sum_ff <= sum_in;
      err_ff <= err_in;  hold_ff <= hold_in;
   end

   always_comb begin
      logic [15:0] l;
      l = rd_data.size - req_ff;
      state_in = state_ff;  total_in = total_ff;  count_in = count_ff;
      ptr_in = ptr_ff;  pos_in = ptr_ff;  rdv_in = 1'b0;
      kind_in = kind_ff;  pid_in = pid_ff;  req_in = req_ff;
      own_in = own_ff;  fit_in = fit_ff;
      best_in = best_ff;  left_in = left_ff;  prev_free_in = prev_free_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  hi_open_in = hi_open_ff;  sum_in = sum_ff;
      err_in = err_ff;  hold_in = hold_ff;
      wr_en = 1'b0;  wr_addr = ptr_ff[IdxW-1:0];  wr_data = '0;
      rd_addr = ptr_ff[IdxW-1:0];
      rsp_valid = 1'b0;  rsp_status = ST_OK;  rsp_seg_size = '0;
      rsp_seg_used = 1'b0;  rsp_seg_owner = '0;  rsp_last = 1'b0;

      unique case (state_ff)
         // Clear sweep: entry 0 gets the total, the rest zero.
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_data.size = (ptr_ff == '0) ? total_ff : 16'd0;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == CntW'(MaxSegs - 1)) begin
               ptr_in = '0;  count_in = CntW'(1);  state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind;  pid_in = req_process_id;  req_in = req_request_size;
               own_in = 1'b0;  fit_in = 1'b0;  prev_free_in = 1'b0;
               hi_open_in = 1'b0;  ptr_in = '0;  state_in = S_SCAN;
            end
         end
         // Scan: issue reads 0..count-1, evaluate each returned entry.
         S_SCAN: begin
            if (ptr_ff < count_ff) begin
               ptr_in = ptr_ff + 1'b1;  rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               prev_free_in = !rd_data.used;
               if (rd_data.used && rd_data.owner == pid_ff && !own_ff) begin
                  own_in = 1'b1;
                  lo_in = prev_free_ff ? lo_ff : pos_ff[IdxW-1:0];
                  hi_in = pos_ff;  hi_open_in = 1'b1;
                  sum_in = rd_data.size + (prev_free_ff ? sum_ff : 16'd0);
               end else if (!rd_data.used) begin
                  if (hi_open_ff) begin
                     hi_in = pos_ff;  sum_in = sum_ff + rd_data.size;
                  end else if (!own_ff) begin
                     if (!prev_free_ff) begin
                        lo_in = pos_ff[IdxW-1:0];  sum_in = rd_data.size;
                     end else begin
                        sum_in = sum_ff + rd_data.size;
                     end
                  end
               end else begin
                  hi_open_in = 1'b0;
               end
               if (!rd_data.used && rd_data.size >= req_ff && (!fit_ff || l < left_ff)) begin
                  fit_in = 1'b1;  best_in = pos_ff[IdxW-1:0];  left_in = l;
               end
            end else if (ptr_ff >= count_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_ERR;
            if (kind_ff == KIND_ALLOC) begin
               if (own_ff) err_in = ST_DUP;
               else if (req_ff == '0 || !fit_ff) err_in = ST_NOFIT;
               else if (left_ff != '0 && count_ff >= CntW'(MaxSegs)) err_in = ST_FULL;
               else begin
                  // Place the allocation; for a split shift the tail up first.
                  wr_en = 1'b1;  wr_addr = best_ff;
                  wr_data.size = req_ff;  wr_data.used = 1'b1;  wr_data.owner = pid_ff;
                  if (left_ff == '0) begin
                     ptr_in = '0;  state_in = S_LIST;
                  end else begin
                     wr_en = 1'b0;  ptr_in = count_ff - 1'b1;  state_in = S_INS;
                  end
               end
            end else if (!own_ff) begin
               err_in = ST_UNKNOWN;
            end else begin
               wr_en = 1'b1;  wr_addr = lo_ff;
               wr_data.size = sum_ff;
               if (hi_ff == CntW'(lo_ff)) begin
                  ptr_in = '0;  state_in = S_LIST;
               end else begin
                  ptr_in = hi_ff + 1'b1;  state_in = S_MERGE;
               end
            end
         end
         // Insert: move entries best+1..count-1 up by one, top first.
         S_INS: begin
            if (!rdv_ff) begin
               if (ptr_ff > CntW'(best_ff)) begin
                  rd_addr = ptr_ff[IdxW-1:0];  rdv_in = 1'b1;
               end else begin
                  wr_en = 1'b1;  wr_addr = best_ff;
                  wr_data.size = req_ff;  wr_data.used = 1'b1;  wr_data.owner = pid_ff;
                  hold_in = '0;  hold_in.size = left_ff;
                  state_in = S_CLOSE;
               end
            end else begin
               wr_en = 1'b1;  wr_addr = IdxW'(pos_ff + 1'b1);  wr_data = rd_data;
               ptr_in = ptr_ff - 1'b1;
            end
         end
         S_CLOSE: begin
            wr_en = 1'b1;
            if (kind_ff == KIND_ALLOC) begin
               wr_addr = best_ff + 1'b1;  wr_data = hold_ff;
               count_in = count_ff + 1'b1;  ptr_in = '0;  state_in = S_LIST;
            end else begin
               wr_addr = ptr_ff[IdxW-1:0];
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == count_ff - 1'b1) begin
                  count_in = count_ff - (hi_ff - CntW'(lo_ff));
                  ptr_in = '0;  state_in = S_LIST;
               end
            end
         end
         // Merge: move entries hi+1..count-1 down by hi-lo, then zero the tail.
         S_MERGE: begin
            if (!rdv_ff) begin
               if (ptr_ff < count_ff) begin
                  rdv_in = 1'b1;
               end else begin
                  ptr_in = count_ff - (hi_ff - CntW'(lo_ff));  state_in = S_CLOSE;
               end
            end else begin
               wr_en = 1'b1;
               wr_addr = IdxW'(pos_ff - (hi_ff - CntW'(lo_ff)));
               wr_data = rd_data;  ptr_in = ptr_ff + 1'b1;
            end
         end
         // List: one word per cycle from the registered read data.
         S_LIST: begin
            if (ptr_ff < count_ff) begin
               ptr_in = ptr_ff + 1'b1;  rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               rsp_valid = 1'b1;  rsp_seg_size = rd_data.size;
               rsp_seg_used = rd_data.used;
               rsp_seg_owner = rd_data.used ? rd_data.owner : 16'd0;
               rsp_last = (pos_ff == count_ff - 1'b1);
               if (rsp_last) state_in = S_ZERO;
            end
         end
         S_ERR: begin
            rsp_valid = 1'b1;  rsp_status = err_ff;  rsp_last = 1'b1;
            state_in = S_IDLE;
         end
         S_ZERO: begin
            ptr_in = '0;  state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase

      // A register write takes the new total and restarts the clear sweep.
      if (csr_we) begin
         total_in = csr_total_size;  ptr_in = '0;  state_in = S_CLEAR;
      end
   end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for best_fit_segment_allocator_top.
// Depends on bfsa_pkg and the allocator RTL; a built-in table model predicts every word.
module tb;
   import bfsa_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] size;
      logic        used;
      logic [15:0] owner;
      logic        last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = 1'b0;
   logic [15:0] req_process_id = '0;
   logic [15:0] req_request_size = '0;
   logic        csr_we = 1'b0;
   logic [15:0] csr_total_size = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_seg_size;
   logic        rsp_seg_used;
   logic [15:0] rsp_seg_owner;
   logic        rsp_last;

   // Model of the segment table.
   logic [15:0] tab_size [MaxSegs];
   logic        tab_used [MaxSegs];
   logic [15:0] tab_owner [MaxSegs];
   int          tab_count;
   word_type    listing_q [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          idle_on = 1'b1;

   best_fit_segment_allocator_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_process_id(req_process_id),
      .req_request_size(req_request_size), .csr_we(csr_we),
      .csr_total_size(csr_total_size), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_seg_size(rsp_seg_size),
      .rsp_seg_used(rsp_seg_used), .rsp_seg_owner(rsp_seg_owner),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void clear_table(input logic [15:0] total);
      for (int i = 0; i < MaxSegs; i++) begin
         tab_size[i] = '0;
         tab_used[i] = 1'b0;
         tab_owner[i] = '0;
      end
      tab_size[0] = total;
      tab_count = 1;
   endfunction

   function automatic void push_error(input logic [2:0] code);
      word_type w;
      w = '{status: code, size: '0, used: 1'b0, owner: '0, last: 1'b1};
      listing_q.insert(listing_q.size(), w);
   endfunction

   function automatic void push_listing();
      word_type w;
      for (int i = 0; i < tab_count; i++) begin
         w.status = ST_OK;
         w.size = tab_size[i];
         w.used = tab_used[i];
         w.owner = tab_used[i] ? tab_owner[i] : 16'd0;
         w.last = (i + 1 == tab_count);
         listing_q.insert(listing_q.size(), w);
      end
   endfunction

   function automatic int owner_index(input logic [15:0] pid);
      for (int i = 0; i < tab_count; i++)
         if (tab_used[i] && tab_owner[i] == pid) return i;
      return -1;
   endfunction

   // Best-fit allocate: least leftover, lowest index on ties; split remainder.
   function automatic void predict_alloc(input logic [15:0] pid, input logic [15:0] req);
      int best;
      int left;
      int l;
      best = -1;
      left = 0;
      if (owner_index(pid) >= 0) begin
         push_error(ST_DUP);
         return;
      end
      if (req == 0) begin
         push_error(ST_NOFIT);
         return;
      end
      for (int i = 0; i < tab_count; i++) begin
         if (!tab_used[i] && tab_size[i] >= req) begin
            l = tab_size[i] - req;
            if (best < 0 || l < left) begin
               best = i;
               left = l;
            end
         end
      end
      if (best < 0) begin
         push_error(ST_NOFIT);
         return;
      end
      if (left > 0) begin
         if (tab_count >= MaxSegs) begin
            push_error(ST_FULL);
            return;
         end
         for (int j = tab_count; j > best + 1; j--) begin
            tab_size[j] = tab_size[j-1];
            tab_used[j] = tab_used[j-1];
            tab_owner[j] = tab_owner[j-1];
         end
         tab_size[best+1] = left[15:0];
         tab_used[best+1] = 1'b0;
         tab_owner[best+1] = '0;
         tab_count++;
      end
      tab_size[best] = req;
      tab_used[best] = 1'b1;
      tab_owner[best] = pid;
      push_listing();
   endfunction

   // Free the owner's segment and merge it with free neighbors.
   function automatic void predict_free(input logic [15:0] pid);
      int k;
      int lo;
      int hi;
      int gap;
      logic [15:0] sum;
      k = owner_index(pid);
      if (k < 0) begin
         push_error(ST_UNKNOWN);
         return;
      end
      lo = k;
      hi = k;
      sum = '0;
      while (lo > 0 && !tab_used[lo-1]) lo--;
      while (hi + 1 < tab_count && !tab_used[hi+1]) hi++;
      for (int i = lo; i <= hi; i++) sum += tab_size[i];
      tab_size[lo] = sum;
      tab_used[lo] = 1'b0;
      tab_owner[lo] = '0;
      gap = hi - lo;
      if (gap > 0) begin
         for (int i = hi + 1; i < tab_count; i++) begin
            tab_size[i-gap] = tab_size[i];
            tab_used[i-gap] = tab_used[i];
            tab_owner[i-gap] = tab_owner[i];
         end
         for (int i = tab_count - gap; i < tab_count; i++) begin
            tab_size[i] = '0;
            tab_used[i] = 1'b0;
            tab_owner[i] = '0;
         end
         tab_count -= gap;
      end
      push_listing();
   endfunction

   // Check each result word against the oldest expected word.
   always @(posedge clock) begin
      word_type w;
      if (!reset && rsp_valid) begin
         if (listing_q.size() == 0) begin
            $error("unexpected word: status %0d size %0d", rsp_status, rsp_seg_size);
            fail_count++;
         end else begin
            w = listing_q.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d actual %0d", w.status, rsp_status);
               fail_count++;
            end
            if (rsp_seg_size !== w.size) begin
               $error("seg_size: expected %0d actual %0d", w.size, rsp_seg_size);
               fail_count++;
            end
            if (rsp_seg_used !== w.used) begin
               $error("seg_used: expected %0d actual %0d", w.used, rsp_seg_used);
               fail_count++;
            end
            if (rsp_seg_owner !== w.owner) begin
               $error("seg_owner: expected %0d actual %0d", w.owner, rsp_seg_owner);
               fail_count++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d actual %0d", w.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted operation or word.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Send one operation word and update the model once busy has dropped.
   task automatic send_op(input logic kind, input logic [15:0] pid, input logic [15:0] req);
      while (idle_on && $urandom_range(99) < 16) @(posedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_process_id <= pid;
      req_request_size <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_ALLOC) predict_alloc(pid, req);
      else predict_free(pid);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (listing_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Write the total size while idle and restart the model table.
   task automatic write_total(input logic [15:0] total);
      drain();
      csr_we <= 1'b1;
      csr_total_size <= total;
      @(posedge clock);
      csr_we <= 1'b0;
      clear_table(total);
   endtask

   task automatic test_reset_table();
      send_op(1'b1, 16'd5, 16'd0);
      send_op(1'b0, 16'd0, 16'd0);
      send_op(1'b0, 16'd1, 16'd11);
      send_op(1'b0, 16'd1, 16'd10);
      send_op(1'b0, 16'd2, 16'd1);
      send_op(1'b1, 16'd1, 16'hFFFF);
   endtask

   task automatic test_extremes();
      write_total(16'hFFFF);
      send_op(1'b0, 16'hFFFF, 16'hFFFF);
      send_op(1'b0, 16'hFFFF, 16'd1);
      send_op(1'b1, 16'hFFFF, 16'd0);
      send_op(1'b0, 16'h0000, 16'd1);
      send_op(1'b0, 16'h5555, 16'hAAAA);
      send_op(1'b1, 16'h0000, 16'd3);
      send_op(1'b1, 16'h1234, 16'd3);
      write_total(16'd0);
      send_op(1'b0, 16'd7, 16'd1);
      send_op(1'b1, 16'd7, 16'd1);
   endtask

   // Fill the table, hit the full case, merge freed neighbors, then take an exact fit.
   task automatic test_full_table();
      write_total(16'd200);
      for (int i = 0; i < MaxSegs; i++) send_op(1'b0, 16'(i + 100), 16'd5);
      send_op(1'b0, 16'd300, 16'd85);
      send_op(1'b1, 16'd101, 16'd0);
      send_op(1'b1, 16'd103, 16'd0);
      send_op(1'b1, 16'd102, 16'd0);
      send_op(1'b0, 16'd301, 16'd15);
   endtask

   // Random traffic mostly on a small set of ids so frees find owners.
   task automatic test_random();
      logic [15:0] pid;
      logic [15:0] req;
      logic kind;
      for (int n = 0; n < 120; n++) begin
         if (n % 40 == 0)
            write_total(n == 80 ? 16'd65535 : 16'($urandom_range(1, 400)));
         idle_on = !(n >= 70 && n < 100);
         kind = $urandom_range(99) < 45;
         pid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
         case ($urandom_range(9))
            0: req = 16'($urandom);
            1: req = 16'd0;
            default: req = 16'($urandom_range(1, 60));
         endcase
         send_op(kind, pid, req);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      clear_table(RESET_TOTAL);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_table();
      test_extremes();
      test_full_table();
      test_random();
      drain();
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
